### rtl/chsu_pkg.sv
package chsu_pkg;

	// input opcodes
	localparam logic [1:0] OP_READING = 2'd0;
	localparam logic [1:0] OP_HOLD    = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_TOL_UPPER  = 2'd0;
	localparam logic [1:0] REG_TOL_LOWER  = 2'd1;
	localparam logic [1:0] REG_TOL_ENABLE = 2'd2;

	localparam int VALUE_W  = 24;
	localparam int TOL_W    = 20;
	localparam int COUNT_W  = 16;
	localparam int SUM_W    = 40;
	localparam int SUMSQ_W  = 62;
	localparam int PROD_W   = 2 * VALUE_W;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 144;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(100);

	// divider: full-width dividend, count-wide divisor, one quotient bit a cycle
	localparam int DIV_W     = SUMSQ_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// square root: radicand of PROD_W bits, one root bit a cycle
	localparam int ROOT_W     = PROD_W / 2;
	localparam int ROOT_CNT_W = $clog2(ROOT_W);
	localparam int ROOT_REM_W = ROOT_W + 3;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_status_t;

endpackage

### rtl/caliper_hold_statistics_unit.sv
// Caliper hold statistics unit.
// Input stream: s_tuser carries the opcode (read, toggle hold, clear), s_tdata
// the signed 24-bit reading in micrometres. Every input transaction gives
// exactly one output transaction on m_tdata: hold state, held value,
// tolerance verdict and the running statistics (count, min, max, mean,
// deviation, saturation flag).
// Tolerances and the tolerance enable are written through cfg_we/cfg_index/
// cfg_data; writes take effect at once. The user must write them only while
// the unit is idle; the unit itself does not enforce this.
// Timing: one item at a time. A reading, clear, unused opcode, hold release
// or refused capture goes straight to the output step and is written to the
// output register once that register is free. A capture that adds a sample
// runs the shared restoring divider twice (mean, then mean of squares) and
// the bit-serial square root; the first sample skips the second division and
// the root. s_tready is high only while the sequencer is idle.
// The output register holds a finished result until m_tready takes it; the
// unit accepts the next item meanwhile, but will not overwrite an unread
// result, so a stalled receiver stalls the sequencer at its last step.
// Reset clears statistics, hold and current value; tolerances 100 um, check disabled.
module caliper_hold_statistics_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [chsu_pkg::IN_W-1:0]    s_tdata,  // reading[23:0]
	input  logic [1:0]                  s_tuser,  // opcode[1:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// hold_on[0], held_value[24:1], in_tolerance[25], sample_count[41:26],
	// minimum[65:42], maximum[89:66], mean[113:90], deviation[137:114],
	// stats_full[138], zero pad[143:139]
	output logic [chsu_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [chsu_pkg::TOL_W-1:0]   cfg_data
);
	import chsu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SQ,
		S_MEAN,
		S_VAR,
		S_ROOT,
		S_DONE
	} state_t;

	state_t state_q;

	logic [TOL_W-1:0] tol_upper_q;
	logic [TOL_W-1:0] tol_lower_q;
	logic             tol_en_q;

	logic signed [VALUE_W-1:0] rd_q;
	logic signed [VALUE_W-1:0] current_q;
	logic                      hold_flag_q;
	logic signed [VALUE_W-1:0] hold_store_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [VALUE_W-1:0] min_q;
	logic signed [VALUE_W-1:0] max_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [SUMSQ_W-1:0]        sum_sq_q;
	logic [VALUE_W-1:0]        mean_q;
	logic [ROOT_W-1:0]         dev_q;
	logic                      full_q;
	logic                      sum_neg_q;
	logic [PROD_W-1:0]         product_q;
	logic                      m_tvalid_q;
	logic [OUT_W-1:0]          m_tdata_q;

	// shared squarer: the new sample while adding, the mean afterwards
	logic signed [VALUE_W-1:0] mul_a;
	logic signed [PROD_W-1:0]  mul_p;

	assign mul_a = (state_q == S_ADD) ? hold_store_q : $signed(mean_q);
	assign mul_p = mul_a * mul_a;

	always_ff @(posedge clk) begin
		product_q <= $unsigned(mul_p);
	end

	// divider and root
	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	iter_status_t        div_stat;
	logic [DIV_W-1:0]    div_quot;
	logic                root_start;
	logic [PROD_W-1:0]   root_rad;
	iter_status_t        root_stat;
	logic [ROOT_W-1:0]   root_val;

	logic [SUM_W-1:0]    sum_mag;
	logic [VALUE_W-1:0]  mean_mag;
	logic signed [PROD_W:0] var_diff;
	logic                count_gt1;

	assign sum_mag   = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
	assign mean_mag  = div_quot[VALUE_W-1:0];
	assign var_diff  = $signed({1'b0, div_quot[PROD_W-1:0]}) - $signed({1'b0, product_q});
	assign root_rad  = var_diff[PROD_W] ? PROD_W'(-var_diff) : var_diff[PROD_W-1:0];
	assign count_gt1 = count_q > COUNT_W'(1);

	assign div_start    = (state_q == S_SQ) ||
	                      ((state_q == S_MEAN) && div_stat.done && count_gt1);
	assign div_dividend = (state_q == S_SQ) ? DIV_W'(sum_mag) : sum_sq_q;
	assign root_start   = (state_q == S_VAR) && div_stat.done;

	chsu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (count_q),
		.status   (div_stat),
		.quotient (div_quot)
	);

	chsu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (root_rad),
		.status   (root_stat),
		.root     (root_val)
	);

	// tolerance band around the held value
	logic signed [VALUE_W+1:0] hold_ext;
	logic signed [VALUE_W+1:0] rd_ext;
	logic signed [VALUE_W+1:0] band_hi;
	logic signed [VALUE_W+1:0] band_lo;
	logic                      tol_ok;

	assign hold_ext = {{2{hold_store_q[VALUE_W-1]}}, hold_store_q};
	assign rd_ext   = {{2{rd_q[VALUE_W-1]}}, rd_q};
	assign band_hi  = hold_ext + $signed({6'b0, tol_upper_q});
	assign band_lo  = hold_ext - $signed({6'b0, tol_lower_q});
	assign tol_ok   = !tol_en_q || ((rd_ext >= band_lo) && (rd_ext <= band_hi));

	logic out_free;
	logic in_fire;

	assign out_free = !m_tvalid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_upper_q <= TOL_RESET;
			tol_lower_q <= TOL_RESET;
			tol_en_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOL_UPPER:  tol_upper_q <= cfg_data;
				REG_TOL_LOWER:  tol_lower_q <= cfg_data;
				REG_TOL_ENABLE: tol_en_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_q         <= '0;
			current_q    <= '0;
			hold_flag_q  <= 1'b0;
			hold_store_q <= '0;
			count_q      <= '0;
			min_q        <= '0;
			max_q        <= '0;
			sum_q        <= '0;
			sum_sq_q     <= '0;
			mean_q       <= '0;
			dev_q        <= '0;
			full_q       <= 1'b0;
			sum_neg_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						rd_q    <= $signed(s_tdata);
						full_q  <= 1'b0;
						state_q <= S_DONE;
						case (s_tuser)
							OP_READING: current_q <= $signed(s_tdata);
							OP_HOLD: begin
								hold_flag_q <= !hold_flag_q;
								if (!hold_flag_q) begin
									hold_store_q <= current_q;
									if (count_q == COUNT_MAX) begin
										full_q <= 1'b1;
									end else begin
										state_q <= S_ADD;
									end
								end
							end
							OP_CLEAR: begin
								count_q  <= '0;
								min_q    <= '0;
								max_q    <= '0;
								sum_q    <= '0;
								sum_sq_q <= '0;
								mean_q   <= '0;
								dev_q    <= '0;
							end
							default: ;
						endcase
					end
				end
				S_ADD: begin
					if (count_q == '0) begin
						min_q <= hold_store_q;
						max_q <= hold_store_q;
					end else begin
						if (hold_store_q < min_q) min_q <= hold_store_q;
						if (hold_store_q > max_q) max_q <= hold_store_q;
					end
					sum_q   <= sum_q + SUM_W'(hold_store_q);
					count_q <= count_q + 1'b1;
					state_q <= S_SQ;
				end
				S_SQ: begin
					// square is in product_q; mean division starts here
					sum_sq_q  <= sum_sq_q + SUMSQ_W'(product_q);
					sum_neg_q <= sum_q[SUM_W-1];
					state_q   <= S_MEAN;
				end
				S_MEAN: begin
					if (div_stat.done) begin
						mean_q <= sum_neg_q ? (~mean_mag + 1'b1) : mean_mag;
						if (count_gt1) begin
							state_q <= S_VAR;
						end else begin
							dev_q   <= '0;
							state_q <= S_DONE;
						end
					end
				end
				S_VAR: begin
					if (div_stat.done) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (root_stat.done) begin
						dev_q   <= root_val;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the previous result has left
					if (out_free) begin
						m_tdata_q  <= {5'b0, full_q, dev_q, mean_q, max_q, min_q, count_q,
						               tol_ok, hold_store_q, hold_flag_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// one item at a time: an accepted transaction drops ready next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// the divider is never restarted mid-division
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// the root unit is only started once the variance division has finished
	assert property (@(posedge clk) disable iff (!arst_n)
		root_start |-> (!root_stat.busy && !div_stat.busy))
		else $error("square root started out of sequence");

	// a refused capture is only reported with a saturated count
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[138]) |-> (m_tdata[41:26] == COUNT_MAX))
		else $error("stats_full without saturated count");

endmodule

### rtl/chsu_div.sv
module chsu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [chsu_pkg::DIV_W-1:0]   dividend,
	input  logic [chsu_pkg::COUNT_W-1:0] divisor,
	output chsu_pkg::iter_status_t      status,
	output logic [chsu_pkg::DIV_W-1:0]   quotient
);
	import chsu_pkg::*;

	logic [DIV_W-1:0]     quot_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [COUNT_W:0] trial;
	logic [COUNT_W:0] trial_diff;
	logic             fits;

	// restoring step: bring down the next dividend bit and try the subtract
	assign trial      = {rem_q, quot_q[DIV_W-1]};
	assign trial_diff = trial - {1'b0, divisor_q};
	assign fits       = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q    <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else if (start) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
			cnt_q     <= DIV_CNT_W'(DIV_W - 1);
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIV_W-2:0], fits};
			rem_q  <= fits ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quot_q;

endmodule

### rtl/chsu_sqrt.sv
module chsu_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [chsu_pkg::PROD_W-1:0]  radicand,
	output chsu_pkg::iter_status_t      status,
	output logic [chsu_pkg::ROOT_W-1:0]  root
);
	import chsu_pkg::*;

	logic [PROD_W-1:0]     rad_q;
	logic [ROOT_REM_W-1:0] rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [ROOT_REM_W-1:0] rem_sh;
	logic [ROOT_REM_W-1:0] trial;
	logic                  fits;

	// digit-by-digit root: take two radicand bits, try (root << 2) | 1
	assign rem_sh = {rem_q[ROOT_REM_W-3:0], rad_q[PROD_W-1:PROD_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= ROOT_CNT_W'(ROOT_W - 1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[PROD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign root        = root_q;

endmodule

### bench/tb_caliper_hold_statistics_unit.sv
module tb_caliper_hold_statistics_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import chsu_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	localparam int PHASES          = 6;
	localparam int PHASE_ITEMS     = 188;
	localparam int RECEIVER_HOLD   = 300;
	localparam int SETTLE_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRILL_LEN       = 24;

	localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] POS_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef struct packed {
		logic [4:0]         pad;
		logic               stats_full;
		logic [VALUE_W-1:0] deviation;
		logic [VALUE_W-1:0] mean;
		logic [VALUE_W-1:0] maximum;
		logic [VALUE_W-1:0] minimum;
		logic [COUNT_W-1:0] sample_count;
		logic               in_tolerance;
		logic [VALUE_W-1:0] held_value;
		logic               hold_on;
	} readout_t;

	// typed rows carry the readout that follows directly from reset or from a
	// single extreme capture; the tolerance check is still off here
	typedef struct packed {
		logic [1:0] op;
		int         rd;
		bit         typed;
		bit         on;
		int         held;
		int         cnt;
		int         mn;
		int         mx;
		int         avg;
		int         dev;
	} drill_row_t;

	drill_row_t drill_rows [DRILL_LEN] = '{
		'{OP_READING,        0, 1, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 1, 1,        0, 1,        0,        0,        0, 0},
		'{OP_HOLD,           0, 1, 0,        0, 1,        0,        0,        0, 0},
		'{OP_READING,  8388607, 1, 0,        0, 1,        0,        0,        0, 0},
		'{OP_HOLD,          -1, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,     8388607, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_READING, -8388608, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_UNUSED,   8388607, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_CLEAR,   -8388608, 1, 0, -8388608, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 1, 1, -8388608, 1, -8388608, -8388608, -8388608, 0},
		'{OP_CLEAR,          0, 1, 1, -8388608, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 1, 0, -8388608, 0,        0,        0,        0, 0},
		'{OP_READING,       -5, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_READING,       -2, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_UNUSED,        -1, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_READING,        1, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 0, 0,        0, 0,        0,        0,        0, 0},
		'{OP_HOLD,           0, 0, 0,        0, 0,        0,        0,        0, 0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic [1:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = '0;
	logic [TOL_W-1:0]    cfg_data = '0;

	caliper_hold_statistics_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// caliper state as the block should hold it
	logic signed [VALUE_W-1:0] cur_pos = '0;
	logic signed [VALUE_W-1:0] held_pos = '0;
	bit                        hold_engaged = 1'b0;
	bit [COUNT_W-1:0]          n_samples = '0;
	logic signed [VALUE_W-1:0] lo_pos = '0;
	logic signed [VALUE_W-1:0] hi_pos = '0;
	logic signed [VALUE_W-1:0] avg_pos = '0;
	bit [VALUE_W-1:0]          spread = '0;
	longint                    acc_sum = 0;
	bit [63:0]                 acc_sq = '0;
	bit [TOL_W-1:0]            tol_up = TOL_RESET;
	bit [TOL_W-1:0]            tol_dn = TOL_RESET;
	bit                        tol_en = 1'b0;

	readout_t expected_readouts [$];
	int       mismatches = 0;
	int       items_sent = 0;
	bit       idling_on = 1'b1;
	bit       receiver_hold_req = 1'b0;
	int       quiet_cycles = 0;

	function automatic bit [63:0] floor_root(bit [63:0] x);
		bit [63:0] root;
		bit [63:0] b;
		root = '0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic void clear_stats();
		n_samples = '0;
		lo_pos = '0;
		hi_pos = '0;
		avg_pos = '0;
		spread = '0;
		acc_sum = 0;
		acc_sq = '0;
	endfunction

	function automatic void add_sample(logic signed [VALUE_W-1:0] v);
		longint    m;
		longint    diff;
		bit [63:0] q;
		bit [63:0] mag;
		if (n_samples == 0) begin
			lo_pos = v;
			hi_pos = v;
		end else begin
			if (v < lo_pos)
				lo_pos = v;
			if (v > hi_pos)
				hi_pos = v;
		end
		acc_sum += longint'(v);
		acc_sq += 64'(longint'(v) * longint'(v));
		n_samples++;
		m = acc_sum / longint'(n_samples);
		avg_pos = VALUE_W'(m);
		if (n_samples > 1) begin
			q = acc_sq / 64'(n_samples);
			diff = longint'(q) - m * m;
			mag = diff < 0 ? 64'(-diff) : 64'(diff);
			spread = VALUE_W'(floor_root(mag));
		end else begin
			spread = '0;
		end
	endfunction

	function automatic readout_t predict_readout(logic [1:0] op, logic signed [VALUE_W-1:0] rd);
		readout_t r;
		bit       refused;
		longint   lo_b;
		longint   hi_b;
		refused = 1'b0;
		case (op)
			OP_READING: cur_pos = rd;
			OP_HOLD: begin
				hold_engaged = !hold_engaged;
				if (hold_engaged) begin
					held_pos = cur_pos;
					if (n_samples == COUNT_MAX)
						refused = 1'b1;
					else
						add_sample(held_pos);
				end
			end
			OP_CLEAR: clear_stats();
			default: ;
		endcase
		r = '0;
		r.in_tolerance = 1'b1;
		if (tol_en) begin
			lo_b = longint'(held_pos) - longint'(tol_dn);
			hi_b = longint'(held_pos) + longint'(tol_up);
			r.in_tolerance = longint'(rd) >= lo_b && longint'(rd) <= hi_b;
		end
		r.hold_on = hold_engaged;
		r.held_value = held_pos;
		r.sample_count = n_samples;
		r.minimum = lo_pos;
		r.maximum = hi_pos;
		r.mean = avg_pos;
		r.deviation = spread;
		r.stats_full = refused;
		return r;
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_readout(readout_t got);
		readout_t want;
		if (expected_readouts.size() == 0) begin
			$display("%0t: unexpected transaction: expected none, got %h", $time, got);
			mismatches++;
			return;
		end
		want = expected_readouts.pop_front();
		check_field("hold_on", want.hold_on, got.hold_on);
		check_field("held_value", $signed(want.held_value), $signed(got.held_value));
		check_field("in_tolerance", want.in_tolerance, got.in_tolerance);
		check_field("sample_count", want.sample_count, got.sample_count);
		check_field("minimum", $signed(want.minimum), $signed(got.minimum));
		check_field("maximum", $signed(want.maximum), $signed(got.maximum));
		check_field("mean", $signed(want.mean), $signed(got.mean));
		check_field("deviation", want.deviation, got.deviation);
		check_field("stats_full", want.stats_full, got.stats_full);
	endfunction

	// extremes, the hold band and its exact edges, small and random values
	function automatic logic [VALUE_W-1:0] next_reading();
		longint off;
		case ($urandom_range(0, 9))
			0: return POS_MAX;
			1: return POS_MIN;
			2, 3: begin
				case ($urandom_range(0, 4))
					0: off = -longint'(tol_dn) - 1;
					1: off = -longint'(tol_dn);
					2: off = longint'(tol_up);
					3: off = longint'(tol_up) + 1;
					default: off = longint'($urandom_range(0, 32'(tol_up) + 32'(tol_dn)))
						- longint'(tol_dn);
				endcase
				return VALUE_W'(longint'(held_pos) + off);
			end
			4, 5: return VALUE_W'(int'($urandom_range(0, 2000)) - 1000);
			default: return VALUE_W'($urandom());
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [VALUE_W-1:0] rd,
			input bit typed, input readout_t typed_want);
		readout_t want;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= rd;
		do @(posedge clk); while (!s_tready);
		want = predict_readout(op, rd);
		expected_readouts.push_back(typed ? typed_want : want);
		items_sent++;
	endtask

	task automatic wait_drained();
		while (expected_readouts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// hold the enable high across the whole sequence and drop it once
	task automatic set_tolerance(input logic [TOL_W-1:0] up, input logic [TOL_W-1:0] dn,
			input bit en);
		cfg_we <= 1'b1;
		cfg_index <= REG_TOL_UPPER;
		cfg_data <= up;
		@(posedge clk);
		cfg_index <= REG_TOL_LOWER;
		cfg_data <= dn;
		@(posedge clk);
		cfg_index <= REG_TOL_ENABLE;
		cfg_data <= TOL_W'(en);
		@(posedge clk);
		cfg_index <= REG_UNMAPPED;
		cfg_data <= TOL_W'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_up = up;
		tol_dn = dn;
		tol_en = en;
	endtask

	always @(posedge clk)
		if (m_tvalid && m_tready)
			check_readout(m_tdata);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (receiver_hold_req) begin
				receiver_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (RECEIVER_HOLD) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		readout_t         typed_want;
		drill_row_t       row;
		logic [TOL_W-1:0] up;
		logic [TOL_W-1:0] dn;
		bit               en;
		int               target;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DRILL_LEN; i++) begin
			row = drill_rows[i];
			typed_want = '0;
			typed_want.hold_on = row.on;
			typed_want.held_value = VALUE_W'(row.held);
			typed_want.in_tolerance = 1'b1;
			typed_want.sample_count = COUNT_W'(row.cnt);
			typed_want.minimum = VALUE_W'(row.mn);
			typed_want.maximum = VALUE_W'(row.mx);
			typed_want.mean = VALUE_W'(row.avg);
			typed_want.deviation = VALUE_W'(row.dev);
			send_item(row.op, VALUE_W'(row.rd), row.typed, typed_want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			s_tvalid <= 1'b0;
			wait_drained();
			case (ph)
				0: begin up = TOL_RESET; dn = TOL_RESET; en = 1'b1; end
				1: begin up = '0; dn = '0; en = 1'b1; end
				2: begin up = '1; dn = '1; en = 1'b1; end
				3: begin
					up = TOL_W'($urandom_range(0, 1000000));
					dn = TOL_W'($urandom_range(0, 1000000));
					en = 1'b1;
				end
				4: begin
					up = TOL_W'($urandom_range(0, 300));
					dn = TOL_W'($urandom_range(0, 300));
					en = 1'b0;
				end
				default: begin up = 1000; dn = 5; en = 1'b1; end
			endcase
			set_tolerance(up, dn, en);
			idling_on = (ph != PHASES - 1);
			// stall the receiver long enough to back the block up to its input
			if (ph == 1)
				receiver_hold_req = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if (hold_engaged)
					send_item(OP_HOLD, next_reading(), 1'b0, '0);
				if ($urandom_range(0, 3) != 0) begin
					send_item(OP_READING, next_reading(), 1'b0, '0);
					send_item(OP_HOLD, next_reading(), 1'b0, '0);
					repeat ($urandom_range(0, 4))
						send_item($urandom_range(0, 5) == 0 ? OP_UNUSED : OP_READING,
							next_reading(), 1'b0, '0);
					send_item(OP_HOLD, next_reading(), 1'b0, '0);
				end else begin
					send_item(2'($urandom_range(0, 3)), next_reading(), 1'b0, '0);
				end
			end
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/chsu_pkg.sv
rtl/chsu_div.sv
rtl/chsu_sqrt.sv
rtl/caliper_hold_statistics_unit.sv
bench/tb_caliper_hold_statistics_unit.sv
